>>> rtl/job_dependency_release_tracker_macros.svh
// Assertion macros for the dependency release tracker.
`ifndef JOB_DEPENDENCY_RELEASE_TRACKER_MACROS_SVH
`define JOB_DEPENDENCY_RELEASE_TRACKER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define JDRT_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define JDRT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

>>> rtl/jdrt_pkg.sv
// Shared codes, widths and types of the dependency release tracker.
package jdrt_pkg;

  // Request kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Job id and list entry layout: id in the low bits, done flag on top
  localparam int ID_W    = 6;
  localparam int ENTRY_W = ID_W + 1;

  // Flags returned by the list update logic
  typedef struct packed {
    logic full;     // append found the list at capacity
    logic qualify;  // list is non-empty and every entry is done
  } upd_flags_t;

endpackage

>>> rtl/jdrt_list_mem.sv
// Slot list memory: one write port, one registered read port.
module jdrt_list_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 60
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write the modified list back
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one list word per cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/jdrt_list_update.sv
// Read-modify logic for one slot list word: append an entry or mark a job done.
module jdrt_list_update
  import jdrt_pkg::*;
#(
  parameter int MAX_DEPS = 8,
  parameter int CW       = 4,
  parameter int DW       = 60
) (
  input  logic [1:0]      kind,
  input  logic            live,
  input  logic [DW-1:0]   word_in,
  input  logic [ID_W-1:0] job_id,
  input  logic [ID_W-1:0] dep_id,
  output logic [DW-1:0]   word_next,
  output upd_flags_t      flags
);

  logic [CW-1:0] cnt;
  logic          list_done;

  // Take the stored count, or an empty list for a slot never written since clear
  assign cnt = live ? word_in[CW-1:0] : '0;

  always_comb begin
    word_next     = word_in;
    list_done     = 1'b1;
    flags.full    = 1'b0;
    flags.qualify = 1'b0;
    case (kind)
      KIND_APPEND: begin
        if (cnt >= CW'(MAX_DEPS)) begin
          flags.full = 1'b1;
        end else begin
          // Place the new entry at the fill position, not yet done
          for (int j = 0; j < MAX_DEPS; j++) begin
            if (CW'(j) == cnt) begin
              word_next[CW + j*ENTRY_W +: ENTRY_W] = {1'b0, dep_id};
            end
          end
          word_next[CW-1:0] = cnt + 1'b1;
        end
      end
      KIND_FINISH: begin
        // Mark matching entries done and check that the rest are done already
        for (int j = 0; j < MAX_DEPS; j++) begin
          if (CW'(j) < cnt) begin
            if (word_in[CW + j*ENTRY_W +: ID_W] == job_id) begin
              word_next[CW + j*ENTRY_W + ID_W] = 1'b1;
            end else if (!word_in[CW + j*ENTRY_W + ID_W]) begin
              list_done = 1'b0;
            end
          end
        end
        flags.qualify = (cnt != '0) && list_done;
      end
      default: begin
        word_next = word_in;
      end
    endcase
  end

endmodule

>>> rtl/job_dependency_release_tracker.sv
// Top level of the job dependency release tracker.
//
// Each job slot keeps a list of up to MAX_DEPS prerequisite jobs in one word of
// an on-chip memory, next to its fill count; a valid bit per slot, cleared at
// reset and by a clear request, makes a slot read as empty, so no clearing pass
// runs after reset. A request is taken when start is high and busy is low.
// Clear and unused kinds are answered from idle; append goes through the APPEND
// state (read the slot word, then write it back). A finished request walks all
// NUM_JOBS slot words through the single memory read port, one per cycle.
// Results come out one per cycle at most, each for exactly one cycle with valid
// high; the receiver cannot stall them, and a finished request reports its
// released slots in ascending order with last on the final one.
module job_dependency_release_tracker
  import jdrt_pkg::*;
#(
  parameter int NUM_JOBS = 64,
  parameter int MAX_DEPS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      kind,
  input  logic [ID_W-1:0] job,
  input  logic [ID_W-1:0] dep_job,
  output logic            valid,
  output logic            release_res,
  output logic [ID_W-1:0] released_job,
  output logic            status,
  output logic            last
);

`include "job_dependency_release_tracker_macros.svh"

  localparam int JW = $clog2(NUM_JOBS);
  localparam int CW = $clog2(MAX_DEPS + 1);
  localparam int DW = CW + MAX_DEPS * ENTRY_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_APPEND = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

  state_t            state;
  logic [NUM_JOBS-1:0] slot_vld;
  logic [JW-1:0]     scan_idx;
  logic [JW-1:0]     item_slot;
  logic [ID_W-1:0]   item_job;
  logic [ID_W-1:0]   item_dep;
  logic              pend_vld;
  logic [JW-1:0]     pend_slot;

  logic              in_range;
  logic [JW-1:0]     rd_addr;
  logic [DW-1:0]     rd_data;
  logic [JW-1:0]     cur_slot;
  logic [1:0]        upd_kind;
  logic              live;
  logic [DW-1:0]     word_next;
  upd_flags_t        flags;
  logic              we;

  assign busy     = (state != ST_IDLE);
  assign in_range = ({1'b0, job} < (ID_W + 1)'(NUM_JOBS));

  // Select the slot word to read next
  always_comb begin
    case (state)
      ST_IDLE:  rd_addr = (kind == KIND_FINISH) ? '0 : job[JW-1:0];
      ST_SCAN:  rd_addr = scan_idx + 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  // Point the update logic at the slot whose word is arriving
  assign cur_slot = (state == ST_APPEND) ? item_slot : scan_idx;
  assign upd_kind = (state == ST_APPEND) ? KIND_APPEND : KIND_FINISH;
  assign live     = slot_vld[cur_slot];
  assign we       = ((state == ST_APPEND) && !flags.full) || ((state == ST_SCAN) && live);

  jdrt_list_mem #(
    .DEPTH (NUM_JOBS),
    .AW    (JW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (cur_slot),
    .wdata (word_next),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  jdrt_list_update #(
    .MAX_DEPS (MAX_DEPS),
    .CW       (CW),
    .DW       (DW)
  ) u_upd (
    .kind      (upd_kind),
    .live      (live),
    .word_in   (rd_data),
    .job_id    (item_job),
    .dep_id    (item_dep),
    .word_next (word_next),
    .flags     (flags)
  );

  // Sequence requests, track slot validity and drive results
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot_vld <= '0;
      pend_vld <= 1'b0;
      valid    <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            item_job  <= job;
            item_dep  <= dep_job;
            item_slot <= job[JW-1:0];
            case (kind)
              KIND_CLEAR: begin
                if (in_range) begin
                  slot_vld[job[JW-1:0]] <= 1'b0;
                end
                valid        <= 1'b1;
                release_res  <= 1'b0;
                released_job <= '0;
                status       <= 1'b0;
                last         <= 1'b1;
              end
              KIND_APPEND: begin
                if (in_range) begin
                  state <= ST_APPEND;
                end else begin
                  valid        <= 1'b1;
                  release_res  <= 1'b0;
                  released_job <= '0;
                  status       <= 1'b0;
                  last         <= 1'b1;
                end
              end
              KIND_FINISH: begin
                state    <= ST_SCAN;
                scan_idx <= '0;
                pend_vld <= 1'b0;
              end
              default: begin
                valid        <= 1'b1;
                release_res  <= 1'b0;
                released_job <= '0;
                status       <= 1'b0;
                last         <= 1'b1;
              end
            endcase
          end
        end
        ST_APPEND: begin
          // Report the append; a full list drops it
          if (!flags.full) begin
            slot_vld[item_slot] <= 1'b1;
          end
          valid        <= 1'b1;
          release_res  <= 1'b0;
          released_job <= '0;
          status       <= flags.full;
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_SCAN: begin
          // Hold one release back so the final one can carry last
          if (flags.qualify) begin
            if (pend_vld) begin
              valid        <= 1'b1;
              release_res  <= 1'b1;
              released_job <= ID_W'(pend_slot);
              status       <= 1'b0;
              last         <= 1'b0;
            end
            pend_vld  <= 1'b1;
            pend_slot <= scan_idx;
          end
          if (scan_idx == JW'(NUM_JOBS - 1)) begin
            state <= ST_FLUSH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_FLUSH: begin
          // Emit the held release as final, or a plain status result
          valid        <= 1'b1;
          release_res  <= pend_vld;
          released_job <= pend_vld ? ID_W'(pend_slot) : '0;
          status       <= 1'b0;
          last         <= 1'b1;
          pend_vld     <= 1'b0;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `JDRT_ASSERT_NOW(a_nonfinal_in_scan, valid && !last, busy, "non-final result outside a scan")
  `JDRT_ASSERT_NOW(a_release_ok, valid && release_res, !status, "release result with error status")
  `JDRT_ASSERT_NOW(a_status_zero_slot, valid && !release_res, released_job == '0, "status result with slot")
  `JDRT_ASSERT_NEXT(a_finish_busy, start && !busy && kind == KIND_FINISH, busy && !valid, "finish not scanning")

endmodule

>>> verif/job_dependency_release_tracker_tb.sv
// Self-checking testbench for the job dependency release tracker.
module job_dependency_release_tracker_tb
  import jdrt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_JOBS = 64;
  localparam int MAX_DEPS = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_ITEMS = 106;
  localparam int MAX_REPORTS = 10;

  // One result as the block presents it
  typedef struct packed {
    logic            rel;
    logic [ID_W-1:0] slot;
    logic            st;
    logic            lst;
  } release_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  logic [1:0]      kind = KIND_CLEAR;
  logic [ID_W-1:0] job = '0;
  logic [ID_W-1:0] dep_job = '0;
  logic            valid;
  logic            release_res;
  logic [ID_W-1:0] released_job;
  logic            status;
  logic            last;

  // Shadow copy of the per-slot dependency lists
  logic [ID_W-1:0] shadow_ids  [NUM_JOBS][MAX_DEPS];
  logic            shadow_done [NUM_JOBS][MAX_DEPS];
  logic [3:0]      shadow_count[NUM_JOBS];

  release_result_t pending_results[$];
  int              fail_count = 0;
  bit              no_idle = 1'b0;

  job_dependency_release_tracker #(
    .NUM_JOBS(NUM_JOBS),
    .MAX_DEPS(MAX_DEPS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .job(job),
    .dep_job(dep_job),
    .valid(valid),
    .release_res(release_res),
    .released_job(released_job),
    .status(status),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic release_result_t make_result(logic rel, logic [ID_W-1:0] slot,
                                                  logic st, logic lst);
    release_result_t r;
    r.rel  = rel;
    r.slot = slot;
    r.st   = st;
    r.lst  = lst;
    return r;
  endfunction

  // Update the shadow lists for one accepted request and queue its results
  function automatic void predict_releases(logic [1:0] k, logic [ID_W-1:0] j,
                                           logic [ID_W-1:0] d);
    logic            full_drop;
    bit              list_done;
    int              cnt;
    int              found;
    release_result_t hits[$];
    full_drop = 1'b0;
    case (k)
      KIND_CLEAR: begin
        if (int'(j) < NUM_JOBS) shadow_count[j] = 4'd0;
      end
      KIND_APPEND: begin
        if (int'(j) < NUM_JOBS) begin
          cnt = int'(shadow_count[j]);
          if (cnt >= MAX_DEPS) begin
            full_drop = 1'b1;
          end else begin
            shadow_ids[j][cnt]  = d;
            shadow_done[j][cnt] = 1'b0;
            shadow_count[j]     = 4'(cnt + 1);
          end
        end
      end
      KIND_FINISH: begin
        // Mark the finished job in every list, then collect fully done slots
        for (int s = 0; s < NUM_JOBS; s++) begin
          cnt = int'(shadow_count[s]);
          if (cnt != 0) begin
            if (cnt > MAX_DEPS) cnt = MAX_DEPS;
            list_done = 1'b1;
            for (int e = 0; e < cnt; e++) begin
              if (shadow_ids[s][e] == j) shadow_done[s][e] = 1'b1;
              else if (!shadow_done[s][e]) list_done = 1'b0;
            end
            if (list_done) hits.push_back(make_result(1'b1, ID_W'(s), 1'b0, 1'b0));
          end
        end
      end
      default: ;
    endcase
    found = hits.size();
    if (found > 0) begin
      hits[found - 1].lst = 1'b1;
      foreach (hits[h]) pending_results.push_back(hits[h]);
    end else begin
      pending_results.push_back(make_result(1'b0, '0, full_drop, 1'b1));
    end
  endfunction

  // Present one request, hold it until taken, then idle for a random gap unless no_idle is set
  task automatic issue_request(logic [1:0] k, logic [ID_W-1:0] j, logic [ID_W-1:0] d);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    kind    <= k;
    job     <= j;
    dep_job <= d;
    do @(posedge clk); while (busy !== 1'b0);
    predict_releases(k, j, d);
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop start and hold off until every queued result has come back
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    release_result_t want;
    if (!rst && $isunknown(valid)) begin
      note_failure("valid is unknown");
    end else if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result rel=%0b slot=%0d status=%0b last=%0b",
                               release_res, released_job, status, last));
      end else begin
        want = pending_results.pop_front();
        if (release_res !== want.rel || released_job !== want.slot ||
            status !== want.st || last !== want.lst)
          note_failure($sformatf({"expected rel=%0b slot=%0d status=%0b last=%0b, ",
                                  "got rel=%0b slot=%0d status=%0b last=%0b"},
                                 want.rel, want.slot, want.st, want.lst,
                                 release_res, released_job, status, last));
      end
    end
  end

  // Finish with every list empty
  task automatic test_empty_finish();
    issue_request(KIND_FINISH, 6'd0, 6'd63);
  endtask

  // Release one slot once both prerequisites are done
  task automatic test_single_release();
    issue_request(KIND_APPEND, 6'd0, 6'd63);
    issue_request(KIND_APPEND, 6'd0, 6'd0);
    issue_request(KIND_FINISH, 6'd63, 6'd0);
    issue_request(KIND_FINISH, 6'd0, 6'd63);
  endtask

  // Fill the top slot to capacity, then overflow it
  task automatic test_full_list();
    logic [ID_W-1:0] deps[MAX_DEPS] = '{6'd0, 6'd63, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32};
    foreach (deps[i]) issue_request(KIND_APPEND, 6'd63, deps[i]);
    issue_request(KIND_APPEND, 6'd63, 6'd7);
  endtask

  task automatic test_unused_kind();
    issue_request(KIND_UNUSED, 6'd63, 6'd63);
  endtask

  // Clear a released slot so it no longer reports
  task automatic test_clear_list();
    issue_request(KIND_CLEAR, 6'd0, 6'd63);
    issue_request(KIND_FINISH, 6'd0, 6'd0);
  endtask

  // Several slots released together, and reported again on a later finish
  task automatic test_multi_release();
    issue_request(KIND_APPEND, 6'd5, 6'd42);
    issue_request(KIND_APPEND, 6'd6, 6'd42);
    issue_request(KIND_FINISH, 6'd42, 6'd21);
    issue_request(KIND_FINISH, 6'd11, 6'd42);
    issue_request(KIND_CLEAR, 6'd5, 6'd0);
    issue_request(KIND_CLEAR, 6'd6, 6'd0);
    issue_request(KIND_CLEAR, 6'd63, 6'd0);
  endtask

  // Mostly dependency chains over a small pool of slots and ids, some noise
  task automatic test_random_traffic();
    logic [ID_W-1:0] slot_pool[8];
    logic [ID_W-1:0] id_pool[12];
    logic [1:0]      k;
    logic [ID_W-1:0] j;
    logic [ID_W-1:0] d;
    int              sel;
    foreach (slot_pool[i]) slot_pool[i] = ID_W'($urandom_range(0, 63));
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 63));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      if (n % 32 == 31) begin
        slot_pool[$urandom_range(0, 7)] = ID_W'($urandom_range(0, 63));
        id_pool[$urandom_range(0, 11)]  = ID_W'($urandom_range(0, 63));
      end
      sel = $urandom_range(0, 99);
      d   = ID_W'($urandom_range(0, 63));
      if (sel < 40) begin
        k = KIND_APPEND;
        j = slot_pool[$urandom_range(0, 7)];
        d = id_pool[$urandom_range(0, 11)];
      end else if (sel < 72) begin
        k = KIND_FINISH;
        j = id_pool[$urandom_range(0, 11)];
      end else if (sel < 82) begin
        k = KIND_CLEAR;
        j = slot_pool[$urandom_range(0, 7)];
      end else if (sel < 88) begin
        k = KIND_UNUSED;
        j = ID_W'($urandom_range(0, 63));
      end else begin
        k = 2'($urandom_range(0, 2));
        j = ID_W'($urandom_range(0, 63));
      end
      issue_request(k, j, d);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (shadow_count[s]) shadow_count[s] = 4'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_finish();
    test_single_release();
    test_full_list();
    test_unused_kind();
    test_clear_list();
    test_multi_release();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> job_dependency_release_tracker.f
+incdir+rtl
rtl/jdrt_pkg.sv
rtl/jdrt_list_mem.sv
rtl/jdrt_list_update.sv
rtl/job_dependency_release_tracker.sv
verif/job_dependency_release_tracker_tb.sv
